// ===== hw/rtl/mfca_pkg.sv =====
// Shared types and constants for the meter frame checksum and address extractor.
// No dependencies; every other file uses these by scoped name.
package mfca_pkg;

  localparam int MAX_FRAME_BYTES = 64;

  // byte position counter only has to reach the last legal checksum position
  localparam int IDX_W  = $clog2(MAX_FRAME_BYTES);
  localparam int CIDX_W = 9;

  localparam logic [7:0] START_MARK = 8'h68;

  localparam logic [IDX_W-1:0] START_POS      = IDX_W'(4);
  localparam int               ADDR_FIRST_POS = 5;
  localparam int               ADDR_BYTES     = 6;
  localparam logic [IDX_W-1:0] LEN_POS        = IDX_W'(13);
  localparam logic [IDX_W-1:0] IDX_MAX        = IDX_W'(MAX_FRAME_BYTES - 1);
  localparam logic [CIDX_W-1:0] CSUM_OFFSET   = CIDX_W'(14);
  localparam logic [CIDX_W-1:0] FRAME_LIMIT   = CIDX_W'(MAX_FRAME_BYTES);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_START = 2'd1;
  localparam logic [1:0] ST_MISMATCH  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } beat_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [47:0] meter_address;
  } result_t;

endpackage

// ===== hw/rtl/mfca_in_stage.sv =====
// Input register of the frame checker: captures one beat per cycle while not stalled.
// Depends on mfca_pkg (beat_t).
module mfca_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  mfca_pkg::beat_t in_beat,
  input  logic          advance,
  output logic          in_stall,
  output logic          beat_valid,
  output mfca_pkg::beat_t beat
);

  // hold only while a captured beat cannot move on
  assign in_stall = beat_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beat <= in_beat;
    end
  end

endmodule

// ===== hw/rtl/mfca_check.sv =====
// Frame state and checking logic: position counter, running sum, address capture.
// Depends on mfca_pkg (beat_t, result_t, status codes, frame constants).
module mfca_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  mfca_pkg::beat_t   beat,
  output logic              res_valid,
  output mfca_pkg::result_t result
);

  logic [mfca_pkg::IDX_W-1:0]  byte_index;
  logic [7:0]                  running_sum;
  logic [mfca_pkg::CIDX_W-1:0] checksum_index;
  logic [47:0]                 address_capture;
  logic                        frame_finished;

  logic [mfca_pkg::IDX_W-1:0]  byte_index_next;
  logic [7:0]                  running_sum_next;
  logic [mfca_pkg::CIDX_W-1:0] checksum_index_next;
  logic [47:0]                 address_capture_next;
  logic                        frame_finished_next;

  logic [mfca_pkg::IDX_W-1:0]  idx;
  logic [mfca_pkg::CIDX_W-1:0] idx_ext;
  logic [7:0]                  sum_add;

  always_comb begin
    // a start byte restarts the frame from a clean slate
    idx                  = beat.frame_start ? '0 : byte_index;
    running_sum_next     = beat.frame_start ? '0 : running_sum;
    checksum_index_next  = beat.frame_start ? '0 : checksum_index;
    address_capture_next = beat.frame_start ? '0 : address_capture;
    frame_finished_next  = beat.frame_start ? 1'b0 : frame_finished;
    idx_ext              = mfca_pkg::CIDX_W'(idx);
    sum_add              = running_sum_next + beat.rx_byte;
    byte_index_next      = byte_index;
    res_valid            = 1'b0;
    result.frame_status  = mfca_pkg::ST_OK;
    result.meter_address = '0;

    if (!frame_finished_next) begin
      byte_index_next = (idx != mfca_pkg::IDX_MAX) ? idx + 1'b1 : idx;

      for (int k = 0; k < mfca_pkg::ADDR_BYTES; k++) begin
        if (idx == mfca_pkg::IDX_W'(mfca_pkg::ADDR_FIRST_POS + k)) begin
          address_capture_next[8*k +: 8] = beat.rx_byte;
        end
      end

      if (idx < mfca_pkg::START_POS) begin
        // preamble: skip
      end else if (idx == mfca_pkg::START_POS && beat.rx_byte != mfca_pkg::START_MARK) begin
        res_valid           = 1'b1;
        result.frame_status = mfca_pkg::ST_BAD_START;
      end else if (idx < mfca_pkg::LEN_POS) begin
        running_sum_next = sum_add;
      end else if (idx == mfca_pkg::LEN_POS) begin
        running_sum_next    = sum_add;
        checksum_index_next = mfca_pkg::CSUM_OFFSET + mfca_pkg::CIDX_W'(beat.rx_byte);
        if (checksum_index_next >= mfca_pkg::FRAME_LIMIT) begin
          res_valid           = 1'b1;
          result.frame_status = mfca_pkg::ST_TOO_LONG;
        end
      end else if (idx_ext < checksum_index_next) begin
        running_sum_next = sum_add;
      end else begin
        res_valid = 1'b1;
        if (running_sum_next == beat.rx_byte) begin
          result.frame_status  = mfca_pkg::ST_OK;
          result.meter_address = address_capture_next;
        end else begin
          result.frame_status = mfca_pkg::ST_MISMATCH;
        end
      end

      if (res_valid) begin
        frame_finished_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      running_sum     <= '0;
      checksum_index  <= '0;
      address_capture <= '0;
      frame_finished  <= 1'b1;
    end else if (advance) begin
      byte_index      <= byte_index_next;
      running_sum     <= running_sum_next;
      checksum_index  <= checksum_index_next;
      address_capture <= address_capture_next;
      frame_finished  <= frame_finished_next;
    end
  end

  a_result_ends_frame: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |=> frame_finished)
    else $error("frame not closed after a result");

  a_idle_is_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && frame_finished && !beat.frame_start |-> !res_valid)
    else $error("result produced while idle");

  a_address_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.frame_status != mfca_pkg::ST_OK |-> result.meter_address == '0)
    else $error("address leaked on a failing status");

  a_idle_state_holds: assert property (@(posedge clk) disable iff (rst)
    advance && frame_finished && !beat.frame_start |=> $stable(byte_index))
    else $error("position moved while idle");

endmodule

// ===== hw/rtl/mfca_out_stage.sv =====
// Result register of the frame checker: holds one result beat until taken.
// Depends on mfca_pkg (result_t).
module mfca_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  mfca_pkg::result_t load_result,
  input  logic              out_stall,
  output logic              load_ready,
  output logic              out_valid,
  output mfca_pkg::result_t out_result
);

  // take a new result when empty or when the held one leaves this cycle
  assign load_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      out_result <= load_result;
    end
  end

endmodule

// ===== hw/rtl/meter_frame_checksum_address_extract_top.sv =====
// Top level of the meter frame checksum and address extractor.
// Depends on mfca_pkg, mfca_in_stage, mfca_check and mfca_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall): one frame byte per beat on rx_byte, with
//   frame_start high on byte 0 of each frame. Bytes arriving while no frame is
//   open and without frame_start are dropped; frame_start mid-frame abandons the
//   open frame silently.
//   Output channel (out_valid / out_stall): at most one result beat per frame,
//   frame_status (ok, bad start, checksum mismatch, too long) and meter_address,
//   which carries frame bytes 5..10 on ok and zero otherwise.
//   Throughput: one byte per cycle while no held result stalls the input, set by the
//   single input register feeding the result register through the checker logic.
//   Result path: the beat completing a frame is held in the input register, then
//   its result is registered in the result register.
//   Reset (rst, synchronous) empties both registers and leaves the checker idle,
//   waiting for frame_start.
//   When out_stall holds a result, one byte can still wait in the input register;
//   further bytes are stalled until the result is taken.
module meter_frame_checksum_address_extract_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [47:0] meter_address
);

  mfca_pkg::beat_t   in_beat;
  mfca_pkg::beat_t   beat;
  mfca_pkg::result_t result;
  mfca_pkg::result_t out_result;
  logic              beat_valid;
  logic              load_ready;
  logic              advance;
  logic              res_valid;

  assign in_beat.rx_byte     = rx_byte;
  assign in_beat.frame_start = frame_start;

  assign advance = beat_valid && load_ready;

  mfca_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_beat    (in_beat),
    .advance    (advance),
    .in_stall   (in_stall),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  mfca_check u_check (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .beat      (beat),
    .res_valid (res_valid),
    .result    (result)
  );

  mfca_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (advance && res_valid),
    .load_result (result),
    .out_stall   (out_stall),
    .load_ready  (load_ready),
    .out_valid   (out_valid),
    .out_result  (out_result)
  );

  assign frame_status  = out_result.frame_status;
  assign meter_address = out_result.meter_address;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for meter_frame_checksum_address_extract_top.
// Depends on mfca_pkg for status codes, the start mark and the result type;
// frames are built here, predicted beat by beat and checked on the output port.
module testbench;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PREAMBLE_LEN = 4;
  localparam int          START_IDX    = 4;
  localparam int          ADDR_IDX     = 5;
  localparam int          ADDR_END_IDX = 11;
  localparam int          LEN_IDX      = 13;
  localparam logic [8:0]  CSUM_OFS     = 9'd14;
  localparam int          MAX_OK_LEN   = mfca_pkg::MAX_FRAME_BYTES - 15;

  typedef logic [7:0] frame_bytes_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  frame_status;
  logic [47:0] meter_address;

  mfca_pkg::result_t pending_results[$];
  int  error_count = 0;
  int  bytes_sent = 0;
  bit  gaps_on = 1'b1;
  bit  hold_results = 1'b0;

  // frame tracker state
  logic [8:0]  frame_pos = '0;
  logic [7:0]  frame_sum = '0;
  logic [8:0]  csum_pos = '0;
  logic [47:0] addr_acc = '0;
  bit          frame_idle = 1'b1;

  meter_frame_checksum_address_extract_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .frame_start   (frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_status  (frame_status),
    .meter_address (meter_address)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the frame tracker by one accepted byte; returns 1 when the byte ends the frame.
  function automatic bit predict_frame_result(input logic [7:0] b, input logic s,
                                              output mfca_pkg::result_t r);
    logic [8:0] pos;
    r = '0;
    if (s) begin
      frame_pos  = '0;
      frame_sum  = '0;
      csum_pos   = '0;
      addr_acc   = '0;
      frame_idle = 1'b0;
    end else if (frame_idle) begin
      return 1'b0;
    end
    pos = frame_pos;
    if (frame_pos != 9'h1FF) frame_pos = frame_pos + 9'd1;
    if (pos < START_IDX) return 1'b0;
    if (pos == START_IDX && b != mfca_pkg::START_MARK) begin
      r.frame_status = mfca_pkg::ST_BAD_START;
      frame_idle = 1'b1;
      return 1'b1;
    end
    if (pos >= ADDR_IDX && pos < ADDR_END_IDX) addr_acc[8*(pos-ADDR_IDX) +: 8] = b;
    if (pos < LEN_IDX) begin
      frame_sum = frame_sum + b;
      return 1'b0;
    end
    if (pos == LEN_IDX) begin
      frame_sum = frame_sum + b;
      csum_pos  = CSUM_OFS + {1'b0, b};
      if (csum_pos >= mfca_pkg::MAX_FRAME_BYTES) begin
        r.frame_status = mfca_pkg::ST_TOO_LONG;
        frame_idle = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (pos < csum_pos) begin
      frame_sum = frame_sum + b;
      return 1'b0;
    end
    frame_idle = 1'b1;
    if (frame_sum == b) begin
      r.frame_status  = mfca_pkg::ST_OK;
      r.meter_address = addr_acc;
    end else begin
      r.frame_status = mfca_pkg::ST_MISMATCH;
    end
    return 1'b1;
  endfunction

  // Header only when the length runs past the buffer; checksum corrupted on request.
  function automatic frame_bytes_t build_frame(input logic [47:0] addr, input logic [7:0] len,
                                               input bit good_csum);
    frame_bytes_t f;
    logic [7:0]   sum;
    sum = '0;
    for (int i = 0; i < PREAMBLE_LEN; i++)
      f.push_back(($urandom_range(0, 1) == 0) ? 8'hFE : 8'($urandom));
    f.push_back(mfca_pkg::START_MARK);
    for (int i = 0; i < 6; i++) f.push_back(addr[8*i +: 8]);
    f.push_back(8'($urandom));
    f.push_back(8'($urandom));
    f.push_back(len);
    if (len > MAX_OK_LEN) return f;
    for (int i = 0; i < len; i++) f.push_back(8'($urandom));
    for (int i = START_IDX; i < f.size(); i++) sum = sum + f[i];
    if (!good_csum) sum = sum ^ 8'($urandom_range(1, 255));
    f.push_back(sum);
    return f;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    bit                taken;
    int                gap;
    int                r;
    mfca_pkg::result_t res;
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
    if (predict_frame_result(b, s, res)) pending_results.push_back(res);
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r < 60)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input frame_bytes_t f, input int count);
    for (int i = 0; i < count && i < f.size(); i++) send_byte(f[i], i == 0);
  endtask

  task automatic test_bad_start();
    frame_bytes_t f;
    f = build_frame(48'h0, 8'd0, 1'b1);
    f[START_IDX] = 8'h69;
    send_frame(f, START_IDX + 1);
    f = build_frame(48'h0, 8'd0, 1'b1);
    f[START_IDX] = 8'hE8;
    send_frame(f, START_IDX + 1);
  endtask

  task automatic test_idle_and_restart();
    frame_bytes_t f;
    send_byte(mfca_pkg::START_MARK, 1'b0);
    f = build_frame(48'h1234_5678_9ABC, 8'd0, 1'b1);
    send_frame(f, 3);
    f = build_frame(48'hFFFF_FFFF_FFFF, 8'd0, 1'b1);
    for (int i = 0; i < PREAMBLE_LEN; i++) f[i] = 8'h00;
    f[f.size()-1] = f[f.size()-1] - 8'd0;
    send_frame(f, f.size());
  endtask

  // Receiver holds off while short frames keep arriving, so the block backs up.
  task automatic test_output_hold();
    frame_bytes_t f;
    gaps_on = 1'b0;
    hold_results = 1'b1;
    for (int n = 0; n < 20; n++) begin
      f = build_frame(48'h0, 8'd0, 1'b1);
      f[START_IDX] = 8'($urandom_range(0, 103));
      send_frame(f, START_IDX + 1);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames(input int target);
    frame_bytes_t f;
    logic [47:0]  addr;
    logic [7:0]   len;
    int           kind;
    int           r;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
      addr = {16'($urandom), 32'($urandom)};
      r = $urandom_range(0, 99);
      if (r < 80)      len = 8'($urandom_range(0, 8));
      else if (r < 95) len = 8'($urandom_range(9, MAX_OK_LEN));
      else             len = 8'(MAX_OK_LEN);
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        f = build_frame(addr, len, 1'b1);
        send_frame(f, f.size());
      end else if (kind < 65) begin
        f = build_frame(addr, len, 1'b0);
        send_frame(f, f.size());
      end else if (kind < 75) begin
        r = $urandom_range(0, 3);
        len = (r == 0) ? 8'(MAX_OK_LEN + 1) : (r == 1) ? 8'hFF :
              8'($urandom_range(MAX_OK_LEN + 1, 255));
        f = build_frame(addr, len, 1'b1);
        send_frame(f, f.size());
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
      end else if (kind < 83) begin
        f = build_frame(addr, len, 1'b1);
        f[START_IDX] = 8'($urandom_range(0, 254));
        if (f[START_IDX] == mfca_pkg::START_MARK) f[START_IDX] = 8'hFF;
        send_frame(f, ($urandom_range(0, 1) == 0) ? START_IDX + 1 : f.size());
      end else if (kind < 93) begin
        // drop the frame part way; the next frame start abandons it
        f = build_frame(addr, len, 1'b1);
        send_frame(f, $urandom_range(1, f.size() - 1));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Output stall: random modes, occasional long stretches, and a held window on request.
  initial begin : result_stall_gen
    int mode;
    int span;
    int stall_left;
    mode = 0;
    span = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        stall_left = HOLD_CYCLES;
        hold_results = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      if (mode == 3 && stall_left == 0 && $urandom_range(0, 29) == 0)
        stall_left = $urandom_range(10, 40);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Sample between edges; a beat is taken at the next rising edge.
  always @(negedge clk) begin
    mfca_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: frame_status %0d meter_address %h",
               frame_status, meter_address);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (frame_status !== want.frame_status) begin
          $error("frame_status expected %0d, got %0d", want.frame_status, frame_status);
          error_count++;
        end
        if (meter_address !== want.meter_address) begin
          $error("meter_address expected %h, got %h", want.meter_address, meter_address);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_bad_start();
    test_idle_and_restart();
    test_output_hold();
    test_random_frames(1150);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
